[sv/svm_pkg.sv]
package svm_pkg;

  localparam int DATA_W       = 32;
  localparam int KIND_W       = 4;
  localparam int REG_IDX_W    = 4;
  localparam int TARGET_W     = 12;
  localparam int STATUS_W     = 3;
  localparam int NUM_REGS     = 12;
  localparam int DIV_CNT_W    = $clog2(DATA_W);

  localparam int STACK_DEPTH_DEF   = 256;
  localparam int PROGRAM_WORDS_DEF = 4096;

  // opcodes
  localparam logic [KIND_W-1:0] OP_HLT = 4'd0;
  localparam logic [KIND_W-1:0] OP_PSH = 4'd1;
  localparam logic [KIND_W-1:0] OP_ADD = 4'd2;
  localparam logic [KIND_W-1:0] OP_POP = 4'd3;
  localparam logic [KIND_W-1:0] OP_MUL = 4'd4;
  localparam logic [KIND_W-1:0] OP_DIV = 4'd5;
  localparam logic [KIND_W-1:0] OP_SUB = 4'd6;
  localparam logic [KIND_W-1:0] OP_SLT = 4'd7;
  localparam logic [KIND_W-1:0] OP_MOV = 4'd8;
  localparam logic [KIND_W-1:0] OP_SET = 4'd9;
  localparam logic [KIND_W-1:0] OP_LOG = 4'd10;
  localparam logic [KIND_W-1:0] OP_IF  = 4'd11;
  localparam logic [KIND_W-1:0] OP_IFN = 4'd12;
  localparam logic [KIND_W-1:0] OP_GLD = 4'd13;
  localparam logic [KIND_W-1:0] OP_GPT = 4'd14;
  localparam logic [KIND_W-1:0] OP_NOP = 4'd15;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_HALT  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_UNK   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DIVZ  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_OVER  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_UNDER = 3'd5;

  // register indexes
  localparam logic [REG_IDX_W-1:0] R_A  = 4'd0;
  localparam logic [REG_IDX_W-1:0] R_B  = 4'd1;
  localparam logic [REG_IDX_W-1:0] R_C  = 4'd2;
  localparam logic [REG_IDX_W-1:0] R_EX = 4'd8;
  localparam logic [REG_IDX_W-1:0] R_IP = 4'd10;
  localparam logic [REG_IDX_W-1:0] R_SP = 4'd11;

  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic [REG_IDX_W-1:0] reg_first;
    logic [REG_IDX_W-1:0] reg_second;
    logic signed [DATA_W-1:0] immediate;
    logic [TARGET_W-1:0]  branch_target;
  } cmd_t;

  typedef struct packed {
    logic [TARGET_W-1:0]      next_ip;
    logic [STATUS_W-1:0]      status;
    logic                     log_valid;
    logic signed [DATA_W-1:0] log_value;
  } rsp_t;

  // instruction length in program words
  function automatic logic [2:0] instr_len(input logic [KIND_W-1:0] kind);
    logic [2:0] len;
    case (kind)
      OP_PSH, OP_LOG, OP_GLD, OP_GPT: len = 3'd2;
      OP_MOV, OP_SET:                 len = 3'd3;
      OP_IF, OP_IFN:                  len = 3'd4;
      default:                        len = 3'd1;
    endcase
    return len;
  endfunction

endpackage

[sv/svm_stream_if.sv]
interface svm_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

[sv/stack_vm_instruction_executor.sv]
// Stack and register machine executor: one fetched instruction per beat.
// cmd carries the decoded instruction (kind, reg_first, reg_second,
// immediate, branch_target); rsp returns next_ip, status and the log value.
// The block takes one instruction at a time. A stack or register operation
// runs through the TOP, SEC, EXEC, WB and OUT states to its result beat on
// rsp; DIV adds the DIV state on the shared restoring divider, and when
// PROGRAM_WORDS is not a power of two the same divider reduces the fetch
// address in the MOD state. cmd.ready is high only while the sequencer is
// idle, so the next instruction waits until the last one has left OUT.
// The result sits in an output register: a new instruction is accepted while
// it waits, and its own result is held back until rsp has taken the old one.
// Reset (rst, synchronous) clears the registers to zero, SP to minus one and
// the halt flag, and drops any pending result. The data stack is not cleared;
// entries never pushed read as undefined.
// Once HLT has run, every instruction answers halted with an unchanged IP.
module stack_vm_instruction_executor #(
  parameter int STACK_DEPTH   = svm_pkg::STACK_DEPTH_DEF,
  parameter int PROGRAM_WORDS = svm_pkg::PROGRAM_WORDS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  svm_stream_if.sink   cmd,
  svm_stream_if.source rsp
);
  import svm_pkg::*;

  localparam int  AW   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam bit  POW2 = ((PROGRAM_WORDS & (PROGRAM_WORDS - 1)) == 0);
  localparam logic signed [DATA_W-1:0] SP_TOP = DATA_W'(STACK_DEPTH - 1);
  localparam logic [DATA_W-1:0] IP_MASK = DATA_W'(PROGRAM_WORDS - 1);
  localparam logic [DATA_W-1:0] PW_VAL  = DATA_W'(PROGRAM_WORDS);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_TOP  = 3'd1;
  localparam logic [2:0] S_SEC  = 3'd2;
  localparam logic [2:0] S_EXEC = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_WB   = 3'd5;
  localparam logic [2:0] S_MOD  = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0]        state;
  logic [2:0]        state_next;
  cmd_t              ins;
  logic [DATA_W-1:0] regs [NUM_REGS];
  logic [DATA_W-1:0] regs_next [NUM_REGS];
  logic              halted;
  logic              halted_next;

  logic [DATA_W-1:0] stack_mem [STACK_DEPTH];
  logic [AW-1:0]     rd_addr;
  logic [DATA_W-1:0] rd_data;
  logic              mem_we;
  logic [AW-1:0]     mem_wa;
  logic [DATA_W-1:0] mem_wd;

  logic [DATA_W-1:0] a_val;
  logic [DATA_W-1:0] b_val;
  logic [DATA_W-1:0] c_val;
  logic [STATUS_W-1:0] status;
  logic [STATUS_W-1:0] exec_status;
  logic [DATA_W-1:0] exec_c;

  logic [DATA_W-1:0] dv_rem;
  logic [DATA_W-1:0] dv_quo;
  logic [DATA_W-1:0] dv_den;
  logic [DIV_CNT_W-1:0] dv_cnt;
  logic              dv_neg;
  logic [DATA_W:0]   dv_shift;
  logic              dv_ge;
  logic [DATA_W-1:0] dv_rem_step;
  logic [DATA_W-1:0] dv_quo_step;

  logic              rsp_valid;
  rsp_t              rsp_data;
  logic [TARGET_W-1:0] ip_out;
  logic              log_valid_hold;
  logic [DATA_W-1:0] log_value_hold;

  logic signed [DATA_W-1:0] sp_s;
  logic [DATA_W-1:0] sp_p1;
  logic [DATA_W-1:0] sp_m1;
  logic [DATA_W-1:0] rd1;
  logic              taken;
  logic              stack_ok;

  assign cmd.ready = (state == S_IDLE);
  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_data;

  assign sp_s  = $signed(regs[R_SP]);
  assign sp_p1 = regs[R_SP] + 32'd1;
  assign sp_m1 = regs[R_SP] - 32'd1;
  assign rd1   = (ins.reg_first < REG_IDX_W'(NUM_REGS)) ? regs[ins.reg_first] : '0;
  assign taken = (ins.kind == OP_IF)  ? (rd1 == ins.immediate) :
                 (ins.kind == OP_IFN) ? (rd1 != ins.immediate) : 1'b0;
  assign stack_ok = !halted && (status == ST_OK);

  // stack read: top while idle, second entry afterwards
  assign rd_addr = (state == S_IDLE) ? regs[R_SP][AW-1:0] : sp_m1[AW-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      stack_mem[mem_wa] <= mem_wd;
    end
    rd_data <= stack_mem[rd_addr];
  end

  // shared divider step
  assign dv_shift    = {dv_rem, dv_quo[DATA_W-1]};
  assign dv_ge       = (dv_shift >= {1'b0, dv_den});
  assign dv_rem_step = dv_ge ? DATA_W'(dv_shift - {1'b0, dv_den}) : dv_shift[DATA_W-1:0];
  assign dv_quo_step = {dv_quo[DATA_W-2:0], dv_ge};

  // check stack and compute the arithmetic result
  always_comb begin
    exec_status = ST_OK;
    exec_c      = '0;
    if (halted) begin
      exec_status = ST_HALT;
    end else begin
      case (ins.kind)
        OP_HLT: exec_status = ST_HALT;
        OP_PSH, OP_GLD: begin
          if (sp_s > SP_TOP - 32'sd1) exec_status = ST_OVER;
          else if (sp_s < -32'sd1)    exec_status = ST_UNDER;
        end
        OP_POP, OP_GPT: begin
          if (sp_s > SP_TOP)       exec_status = ST_OVER;
          else if (sp_s < 32'sd0)  exec_status = ST_UNDER;
        end
        OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_SLT: begin
          if (sp_s > SP_TOP)                         exec_status = ST_OVER;
          else if (sp_s < 32'sd1)                    exec_status = ST_UNDER;
          else if (ins.kind == OP_DIV && a_val == '0) exec_status = ST_DIVZ;
        end
        default: exec_status = ST_OK;
      endcase
    end
    case (ins.kind)
      OP_ADD:  exec_c = b_val + a_val;
      OP_SUB:  exec_c = b_val - a_val;
      OP_MUL:  exec_c = b_val * a_val;
      OP_SLT:  exec_c = {{(DATA_W-1){1'b0}}, ($signed(a_val) < $signed(b_val))};
      default: exec_c = '0;
    endcase
  end

  // architectural update of the writeback cycle
  always_comb begin
    regs_next   = regs;
    halted_next = halted;
    mem_we      = 1'b0;
    mem_wa      = sp_p1[AW-1:0];
    mem_wd      = c_val;
    if (state == S_WB && !halted) begin
      if (ins.kind == OP_HLT) halted_next = 1'b1;
      if (stack_ok) begin
        case (ins.kind)
          OP_PSH, OP_GLD: begin
            mem_we = 1'b1;
            mem_wd = (ins.kind == OP_PSH) ? ins.immediate : rd1;
            regs_next[R_SP] = sp_p1;
          end
          OP_POP: regs_next[R_SP] = sp_m1;
          OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
            regs_next[R_A]  = a_val;
            regs_next[R_B]  = b_val;
            regs_next[R_C]  = c_val;
            regs_next[R_SP] = sp_m1;
            mem_we = 1'b1;
            mem_wa = sp_m1[AW-1:0];
          end
          OP_SLT: begin
            regs_next[R_SP] = sp_m1;
            mem_we = 1'b1;
            mem_wa = sp_m1[AW-1:0];
          end
          OP_MOV: begin
            if (ins.reg_second < REG_IDX_W'(NUM_REGS)) regs_next[ins.reg_second] = rd1;
          end
          OP_SET: begin
            if (ins.reg_first < REG_IDX_W'(NUM_REGS)) regs_next[ins.reg_first] = ins.immediate;
          end
          OP_IF, OP_IFN: begin
            if (taken) begin
              regs_next[R_EX] = {{(DATA_W-TARGET_W){1'b0}}, ins.branch_target};
              regs_next[R_IP] = {{(DATA_W-TARGET_W){1'b0}}, ins.branch_target} + 32'd1;
            end
          end
          OP_GPT: begin
            if (ins.reg_first < REG_IDX_W'(NUM_REGS)) regs_next[ins.reg_first] = a_val;
          end
          default: ;
        endcase
      end
      // advance past the instruction unless a branch was taken
      if (!(stack_ok && taken)) begin
        regs_next[R_IP] = regs_next[R_IP] + {29'd0, instr_len(ins.kind)};
      end
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (cmd.valid) state_next = S_TOP;
      S_TOP:  state_next = S_SEC;
      S_SEC:  state_next = S_EXEC;
      S_EXEC: state_next = (exec_status == ST_OK && ins.kind == OP_DIV) ? S_DIV : S_WB;
      S_DIV:  if (dv_cnt == DIV_CNT_W'(DATA_W - 1)) state_next = S_WB;
      S_WB:   state_next = POW2 ? S_OUT : S_MOD;
      S_MOD:  if (dv_cnt == DIV_CNT_W'(DATA_W - 1)) state_next = S_OUT;
      S_OUT:  if (!rsp_valid || rsp.ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // control state and architectural registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      halted    <= 1'b0;
      rsp_valid <= 1'b0;
      for (int i = 0; i < NUM_REGS; i++) begin
        regs[i] <= '0;
      end
      regs[R_SP] <= '1;
    end else begin
      state  <= state_next;
      halted <= halted_next;
      regs   <= regs_next;
      if (state == S_OUT && (!rsp_valid || rsp.ready)) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      ins <= cmd.data;
    end
    if (state == S_TOP) a_val <= rd_data;
    if (state == S_SEC) b_val <= rd_data;
    if (state == S_EXEC) begin
      status <= exec_status;
      c_val  <= exec_c;
      // load the divider with magnitudes of the operands
      dv_rem <= '0;
      dv_quo <= b_val[DATA_W-1] ? -b_val : b_val;
      dv_den <= a_val[DATA_W-1] ? -a_val : a_val;
      dv_neg <= a_val[DATA_W-1] ^ b_val[DATA_W-1];
      dv_cnt <= '0;
    end
    if (state == S_DIV || state == S_MOD) begin
      dv_rem <= dv_rem_step;
      dv_quo <= dv_quo_step;
      dv_cnt <= dv_cnt + 1'b1;
    end
    if (state == S_DIV && dv_cnt == DIV_CNT_W'(DATA_W - 1)) begin
      c_val <= dv_neg ? -dv_quo_step : dv_quo_step;
    end
    if (state == S_WB) begin
      log_valid_hold <= !halted && (ins.kind == OP_LOG);
      log_value_hold <= (!halted && ins.kind == OP_LOG) ? rd1 : '0;
      ip_out <= DATA_W'(regs_next[R_IP] & IP_MASK) >> 0 == 0 ? '0 :
                TARGET_W'(regs_next[R_IP] & IP_MASK);
      // reduce the fetch address by the program size
      dv_rem <= '0;
      dv_quo <= regs_next[R_IP];
      dv_den <= PW_VAL;
      dv_cnt <= '0;
    end
    if (state == S_MOD && dv_cnt == DIV_CNT_W'(DATA_W - 1)) begin
      ip_out <= dv_rem_step[TARGET_W-1:0];
    end
    if (state == S_OUT && (!rsp_valid || rsp.ready)) begin
      rsp_data.next_ip   <= ip_out;
      rsp_data.status    <= status;
      rsp_data.log_valid <= log_valid_hold;
      rsp_data.log_value <= log_value_hold;
    end
  end

endmodule

[tb/stack_vm_instruction_executor_tb.sv]
module stack_vm_instruction_executor_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import svm_pkg::*;

  localparam int DEPTH      = STACK_DEPTH_DEF;
  localparam int STALL_MAX  = 3000;
  localparam int HOLD_LEN   = 400;
  localparam int HOLD_AT    = 300;
  localparam int RAND_ITEMS = 700;

  logic clk;
  logic rst;

  svm_stream_if #(.payload_t(cmd_t)) cmd_if ();
  svm_stream_if #(.payload_t(rsp_t)) rsp_if ();

  stack_vm_instruction_executor i_dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_if.sink),
    .rsp(rsp_if.source)
  );

  // machine shadow: registers, data stack with written flags, halt flag
  logic [DATA_W-1:0] vm_regs [NUM_REGS];
  logic [DATA_W-1:0] vm_stack [DEPTH];
  bit                vm_written [DEPTH];
  bit                vm_halted;

  cmd_t instr_q [$];
  rsp_t instr_rsp_q [$];
  rsp_t rsp_offered;
  rsp_t expected_rsp_q [$];

  int src_idle;
  int snk_idle;
  int mismatches;
  int rsp_count;
  int stall_cycles;
  int hold_left;
  bit hold_done;

  function automatic logic [DATA_W-1:0] reg_read(logic [REG_IDX_W-1:0] idx);
    return (idx < NUM_REGS) ? vm_regs[idx] : '0;
  endfunction

  function automatic void reg_write(logic [REG_IDX_W-1:0] idx, logic [DATA_W-1:0] v);
    if (idx < NUM_REGS) vm_regs[idx] = v;
  endfunction

  function automatic int sp_now();
    return $signed(vm_regs[R_SP]);
  endfunction

  function automatic logic [STATUS_W-1:0] entries_status(int sp, int n);
    if (sp > DEPTH - 1) return ST_OVER;
    if (sp < n - 1) return ST_UNDER;
    return ST_OK;
  endfunction

  function automatic logic [STATUS_W-1:0] push_status(int sp);
    if (sp > DEPTH - 2) return ST_OVER;
    if (sp < -1) return ST_UNDER;
    return ST_OK;
  endfunction

  // true when the instruction would read a stack entry never pushed
  function automatic bit hits_unwritten(cmd_t c);
    int sp;
    sp = sp_now();
    if (vm_halted) return 0;
    case (c.kind)
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_SLT:
        return entries_status(sp, 2) == ST_OK && (!vm_written[sp] || !vm_written[sp-1]);
      OP_GPT:
        return entries_status(sp, 1) == ST_OK && !vm_written[sp];
      default: return 0;
    endcase
  endfunction

  // execute one instruction on the shadow and return its response
  function automatic rsp_t execute(cmd_t c);
    rsp_t r;
    int sp;
    logic [DATA_W-1:0] a, b, v;
    logic [2:0] len;
    bit taken;
    r = '0;
    sp = sp_now();
    taken = 0;
    len = 3'd1;
    if (vm_halted) begin
      r.status = ST_HALT;
    end else begin
      case (c.kind)
        OP_HLT: begin
          vm_halted = 1;
          r.status = ST_HALT;
        end
        OP_PSH, OP_GLD: begin
          v = (c.kind == OP_PSH) ? c.immediate : reg_read(c.reg_first);
          len = 3'd2;
          r.status = push_status(sp);
          if (r.status == ST_OK) begin
            vm_stack[sp+1] = v;
            vm_written[sp+1] = 1;
            vm_regs[R_SP] = sp + 1;
          end
        end
        OP_POP: begin
          r.status = entries_status(sp, 1);
          if (r.status == ST_OK) vm_regs[R_SP] = sp - 1;
        end
        OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
          r.status = entries_status(sp, 2);
          if (r.status == ST_OK) begin
            a = vm_stack[sp];
            b = vm_stack[sp-1];
            if (c.kind == OP_DIV && a == 0) begin
              r.status = ST_DIVZ;
            end else begin
              case (c.kind)
                OP_ADD: v = b + a;
                OP_SUB: v = b - a;
                OP_MUL: v = b * a;
                default: begin
                  // minimum over minus one wraps back to minimum
                  if (b == 32'h8000_0000 && a == '1) v = b;
                  else v = $signed(b) / $signed(a);
                end
              endcase
              vm_regs[R_A] = a;
              vm_regs[R_B] = b;
              vm_regs[R_C] = v;
              vm_regs[R_SP] = sp - 1;
              vm_stack[sp-1] = v;
            end
          end
        end
        OP_SLT: begin
          r.status = entries_status(sp, 2);
          if (r.status == ST_OK) begin
            vm_stack[sp-1] = ($signed(vm_stack[sp]) < $signed(vm_stack[sp-1])) ? 1 : 0;
            vm_regs[R_SP] = sp - 1;
          end
        end
        OP_MOV: begin
          reg_write(c.reg_second, reg_read(c.reg_first));
          len = 3'd3;
        end
        OP_SET: begin
          reg_write(c.reg_first, c.immediate);
          len = 3'd3;
        end
        OP_LOG: begin
          r.log_valid = 1;
          r.log_value = reg_read(c.reg_first);
          len = 3'd2;
        end
        OP_IF, OP_IFN: begin
          len = 3'd4;
          if ((reg_read(c.reg_first) == c.immediate) == (c.kind == OP_IF)) begin
            vm_regs[R_EX] = c.branch_target;
            vm_regs[R_IP] = c.branch_target + 1;
            taken = 1;
          end
        end
        OP_GPT: begin
          len = 3'd2;
          r.status = entries_status(sp, 1);
          if (r.status == ST_OK) reg_write(c.reg_first, vm_stack[sp]);
        end
        default: ;
      endcase
      if (!taken) vm_regs[R_IP] = vm_regs[R_IP] + len;
    end
    r.next_ip = vm_regs[R_IP][TARGET_W-1:0];
    return r;
  endfunction

  // queue one instruction; a read of a never pushed entry becomes a no-op
  task automatic add_instr(cmd_t c);
    if (hits_unwritten(c)) c.kind = OP_NOP;
    instr_rsp_q.push_back(execute(c));
    instr_q.push_back(c);
  endtask

  function automatic cmd_t mk(logic [KIND_W-1:0] k, logic [REG_IDX_W-1:0] r1,
                              logic [REG_IDX_W-1:0] r2, logic [DATA_W-1:0] imm,
                              logic [TARGET_W-1:0] tgt);
    cmd_t c;
    c.kind = k;
    c.reg_first = r1;
    c.reg_second = r2;
    c.immediate = imm;
    c.branch_target = tgt;
    return c;
  endfunction

  function automatic logic [DATA_W-1:0] rand_value();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '1;
      3: return $urandom_range(8);
      default: return $urandom;
    endcase
  endfunction

  // mostly well-formed stack programs, some noise on registers and SP
  function automatic cmd_t rand_instr();
    cmd_t c;
    int sp;
    logic [KIND_W-1:0] ops [13];
    ops = '{OP_PSH, OP_ADD, OP_POP, OP_MUL, OP_DIV, OP_SUB, OP_SLT, OP_MOV,
            OP_SET, OP_LOG, OP_IF, OP_IFN, OP_GPT};
    sp = sp_now();
    c = mk(OP_NOP, REG_IDX_W'($urandom_range(11)), REG_IDX_W'($urandom_range(11)),
           rand_value(), TARGET_W'($urandom));
    if ($urandom_range(99) < 15) begin
      c.kind = KIND_W'($urandom_range(1, 15));
      c.reg_first = REG_IDX_W'($urandom_range(15));
      c.reg_second = REG_IDX_W'($urandom_range(15));
      if ($urandom_range(3) == 0) begin
        c.kind = OP_SET;
        c.reg_first = R_SP;
        case ($urandom_range(4))
          0: c.immediate = -2;
          1: c.immediate = DEPTH - 3;
          2: c.immediate = DEPTH - 2;
          3: c.immediate = DEPTH;
          default: c.immediate = $urandom;
        endcase
      end
    end else if (sp < -1 || sp > DEPTH - 2) begin
      c = mk(OP_SET, R_SP, REG_IDX_W'($urandom_range(15)), -1, TARGET_W'($urandom));
    end else if (sp < 1 || $urandom_range(4) == 0) begin
      c.kind = $urandom_range(3) == 0 ? OP_GLD : OP_PSH;
    end else begin
      c.kind = ops[$urandom_range(12)];
      // keep SP out of MOV and SET targets in the regular mix
      if ((c.kind == OP_MOV && c.reg_second == R_SP) ||
          (c.kind == OP_SET && c.reg_first == R_SP)) c.kind = OP_LOG;
    end
    if ((c.kind == OP_IF || c.kind == OP_IFN) && $urandom_range(1))
      c.immediate = reg_read(c.reg_first);
    return c;
  endfunction

  task automatic wait_drained();
    while (instr_q.size() > 0 || cmd_if.valid || expected_rsp_q.size() > 0)
      @(posedge clk);
  endtask

  // clock, reset, init
  initial begin
    clk = 0;
    rst = 1;
    cmd_if.valid = 0;
    cmd_if.data = '0;
    rsp_if.ready = 0;
    forever #1 clk = ~clk;
  end

  // drive instruction beats from the pending queue
  always @(posedge clk) begin
    if (rst) begin
      cmd_if.valid <= 0;
    end else begin
      if (cmd_if.valid && cmd_if.ready) expected_rsp_q.push_back(rsp_offered);
      if (!cmd_if.valid || cmd_if.ready) begin
        if (instr_q.size() > 0 && $urandom_range(99) >= src_idle) begin
          cmd_if.data <= instr_q.pop_front();
          rsp_offered = instr_rsp_q.pop_front();
          cmd_if.valid <= 1;
        end else begin
          cmd_if.valid <= 0;
        end
      end
    end
  end

  // check response beats and drive ready, with one long hold-off
  always @(posedge clk) begin
    rsp_t exp_r;
    if (rst) begin
      rsp_if.ready <= 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        rsp_count++;
        if (expected_rsp_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected response beat %p", rsp_if.data);
        end else begin
          exp_r = expected_rsp_q.pop_front();
          if (rsp_if.data.next_ip !== exp_r.next_ip || rsp_if.data.status !== exp_r.status ||
              rsp_if.data.log_valid !== exp_r.log_valid ||
              rsp_if.data.log_value !== exp_r.log_value) begin
            mismatches++;
            if (mismatches <= 10)
              $display("response %0d mismatch: expected %p, got %p",
                       rsp_count, exp_r, rsp_if.data);
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 0;
      end else if (!hold_done && rsp_count >= HOLD_AT) begin
        hold_done = 1;
        hold_left = HOLD_LEN;
        rsp_if.ready <= 0;
      end else begin
        rsp_if.ready <= $urandom_range(99) >= snk_idle;
      end
    end
  end

  // stop when no beat moves on either side for too long
  always @(posedge clk) begin
    if (rst || (cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      stall_cycles = 0;
    end else if (++stall_cycles >= STALL_MAX) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    cmd_t halt_c;
    src_idle = 7;
    snk_idle = 66;
    for (int i = 0; i < NUM_REGS; i++) vm_regs[i] = '0;
    vm_regs[R_SP] = '1;
    vm_halted = 0;
    for (int i = 0; i < DEPTH; i++) vm_written[i] = 0;
    repeat (9) @(posedge clk);
    rst <= 0;

    // directed: faults on empty stack, divide corners, registers, branches, SP
    add_instr(mk(OP_POP, 0, 0, 0, 0));
    add_instr(mk(OP_GPT, 0, 0, 0, 0));
    add_instr(mk(OP_ADD, 0, 0, 0, 0));
    add_instr(mk(OP_PSH, 0, 0, 32'h8000_0000, 0));
    add_instr(mk(OP_PSH, 0, 0, '1, 0));
    add_instr(mk(OP_DIV, 0, 0, 0, 0));
    add_instr(mk(OP_PSH, 0, 0, 0, 0));
    add_instr(mk(OP_DIV, 0, 0, 0, 0));
    add_instr(mk(OP_PSH, 0, 0, 7, 0));
    add_instr(mk(OP_SUB, 0, 0, 0, 0));
    add_instr(mk(OP_PSH, 0, 0, 32'h7fff_ffff, 0));
    add_instr(mk(OP_MUL, 0, 0, 0, 0));
    add_instr(mk(OP_PSH, 0, 0, 5, 0));
    add_instr(mk(OP_SLT, 0, 0, 0, 0));
    add_instr(mk(OP_GPT, 3, 0, 0, 0));
    add_instr(mk(OP_GLD, R_IP, 0, 0, 0));
    add_instr(mk(OP_MOV, 3, 15, 0, 0));
    add_instr(mk(OP_LOG, 14, 15, 0, 0));
    add_instr(mk(OP_SET, 4, 0, 32'h7fff_ffff, 0));
    add_instr(mk(OP_IF, 4, 0, 32'h7fff_ffff, 12'hfff));
    add_instr(mk(OP_IFN, 4, 0, 32'h7fff_ffff, 12'h0));
    add_instr(mk(OP_SET, R_IP, 0, 32'hffff_fffe, 0));
    add_instr(mk(OP_SET, R_SP, 0, DEPTH - 2, 0));
    add_instr(mk(OP_PSH, 0, 0, 1, 0));
    add_instr(mk(OP_SET, R_SP, 0, -2, 0));
    add_instr(mk(OP_GLD, 0, 0, 0, 0));
    add_instr(mk(OP_SET, R_SP, 0, -1, 0));

    // random, with the idle mix switched between phases
    for (int ph = 0; ph < 3; ph++) begin
      wait_drained();
      src_idle = (ph == 1) ? 66 : (ph == 0 ? 7 : 0);
      snk_idle = (ph == 0) ? 66 : (ph == 1 ? 7 : 0);
      for (int i = 0; i < RAND_ITEMS / 3; i++) add_instr(rand_instr());
    end

    // halt, then show the machine stays halted
    halt_c = mk(OP_HLT, 0, 0, 0, 0);
    add_instr(halt_c);
    add_instr(mk(OP_PSH, 0, 0, 3, 0));
    add_instr(mk(OP_LOG, 1, 0, 0, 0));
    wait_drained();
    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
sv/svm_pkg.sv
sv/svm_stream_if.sv
sv/stack_vm_instruction_executor.sv
tb/stack_vm_instruction_executor_tb.sv
